@@ hdl/command_frame_receive_checker_assert.svh @@
// Assertion macros for the command frame receive checker.
// Used by the checker module; expects clk_i and rst_ni in scope.
`ifndef COMMAND_FRAME_RECEIVE_CHECKER_ASSERT_SVH
`define COMMAND_FRAME_RECEIVE_CHECKER_ASSERT_SVH

// same-cycle implication
`define CFRC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cfrc assertion failed");

// next-cycle implication
`define CFRC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cfrc assertion failed");

`endif

@@ hdl/cfrc_pkg.sv @@
// Shared types, register indexes and CRC-16/XMODEM byte update for the
// command frame receive checker. No dependencies.
package cfrc_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CFG_HOST_MODE     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_EXP_OPCODE    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_REQ_START     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_RSP_START     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SKIP_CRC      = 3'd4;

  typedef enum logic [2:0] {
    STAT_IN_FRAME  = 3'd0,
    STAT_OK        = 3'd1,
    STAT_BAD_START = 3'd2,
    STAT_BAD_LEN   = 3'd3,
    STAT_OPCODE    = 3'd4,
    STAT_CRC       = 3'd5
  } status_e;

  localparam logic [15:0] CrcPoly = 16'h1021;

  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ hdl/cfrc_if.sv @@
// Valid/ready channel interfaces for received bytes and per-byte status.
// Depends on nothing.
interface cfrc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source(output valid, output rx_byte, input ready);
  modport sink(input valid, input rx_byte, output ready);
endinterface

interface cfrc_st_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        frame_end;
  logic [7:0]  frame_opcode;
  logic [10:0] payload_length;
  modport source(output valid, output status, output frame_end, output frame_opcode,
                 output payload_length, input ready);
  modport sink(input valid, input status, input frame_end, input frame_opcode,
               input payload_length, output ready);
endinterface

@@ hdl/command_frame_receive_checker.sv @@
// Command frame receive checker: one status transaction per received byte.
// Result: status valid in the cycle after the byte transaction is accepted.
// Throughput: one byte per cycle; a byte enters in the cycle its predecessor's
// status is taken, and a stalled status holds off the input.
// Reset: asynchronous; clears configuration, frame state and output valid, awaits a start byte.
// Depends on cfrc_pkg and cfrc_if.
module command_frame_receive_checker #(
  parameter int unsigned MAX_FRAME_BYTES = 1040
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cfrc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cfrc_pkg::CfgDataW-1:0] cfg_data_i,
  cfrc_rx_if.sink                       rx_i,
  cfrc_st_if.source                     st_o
);

  localparam int unsigned PosW     = $clog2(MAX_FRAME_BYTES);
  localparam logic [16:0] MaxBytes = 17'(MAX_FRAME_BYTES);

  logic       host_mode_q;
  logic [7:0] exp_opcode_q;
  logic [7:0] req_start_q;
  logic [7:0] rsp_start_q;
  logic       skip_crc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      host_mode_q  <= 1'b0;
      exp_opcode_q <= 8'h00;
      req_start_q  <= 8'h00;
      rsp_start_q  <= 8'h00;
      skip_crc_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cfrc_pkg::CFG_HOST_MODE:  host_mode_q  <= cfg_data_i[0];
        cfrc_pkg::CFG_EXP_OPCODE: exp_opcode_q <= cfg_data_i;
        cfrc_pkg::CFG_REQ_START:  req_start_q  <= cfg_data_i;
        cfrc_pkg::CFG_RSP_START:  rsp_start_q  <= cfg_data_i;
        cfrc_pkg::CFG_SKIP_CRC:   skip_crc_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      start_q, start_d;
  logic [15:0]     len_q, len_d;
  logic [7:0]      op_q, op_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      crcl_q, crcl_d;

  logic                 out_valid_q;
  cfrc_pkg::status_e    status_q, status_d;
  logic                 end_q, end_d;
  logic [7:0]           fop_q, fop_d;
  logic [10:0]          plen_q, plen_d;

  logic        accept;
  logic [7:0]  b;
  logic [15:0] crc_next;
  logic [15:0] len_new;
  logic [16:0] pos_ext;
  logic [16:0] len_end;
  logic [15:0] got;
  logic [7:0]  want_start;
  logic [15:0] len_m1;

  assign rx_i.ready = !out_valid_q || st_o.ready;
  assign accept     = rx_i.valid && rx_i.ready;
  assign b          = rx_i.rx_byte;
  assign crc_next   = cfrc_pkg::crc16_feed(crc_q, b);
  assign len_new    = {b, len_q[7:0]};
  assign pos_ext    = 17'(pos_q);
  assign len_end    = {1'b0, len_q} + 17'd3;
  assign got        = {b, crcl_q};
  assign want_start = host_mode_q ? rsp_start_q : req_start_q;
  assign len_m1     = len_q - 16'd1;

  always_comb begin
    pos_d    = pos_q;
    start_d  = start_q;
    len_d    = len_q;
    op_d     = op_q;
    crc_d    = crc_q;
    crcl_d   = crcl_q;
    status_d = cfrc_pkg::STAT_IN_FRAME;
    end_d    = 1'b0;
    fop_d    = 8'h00;
    plen_d   = 11'd0;
    if (pos_q == PosW'(0)) begin
      start_d = b;
      crc_d   = 16'h0000;
      len_d   = 16'h0000;
      op_d    = 8'h00;
      crcl_d  = 8'h00;
      pos_d   = PosW'(1);
    end else if (pos_q == PosW'(1)) begin
      len_d = {8'h00, b};
      crc_d = crc_next;
      pos_d = PosW'(2);
    end else if (pos_q == PosW'(2)) begin
      len_d = len_new;
      crc_d = crc_next;
      if (len_new == 16'h0000 || ({1'b0, len_new} + 17'd5) > MaxBytes) begin
        status_d = cfrc_pkg::STAT_BAD_LEN;
        end_d    = 1'b1;
        pos_d    = PosW'(0);
      end else begin
        pos_d = PosW'(3);
      end
    end else if (pos_ext < len_end) begin
      if (pos_q == PosW'(3)) begin
        op_d = b;
      end
      crc_d = crc_next;
      pos_d = pos_q + PosW'(1);
    end else if (pos_ext == len_end) begin
      crcl_d = b;
      pos_d  = pos_q + PosW'(1);
    end else begin
      if (start_q != want_start) begin
        status_d = cfrc_pkg::STAT_BAD_START;
      end else if (host_mode_q && op_q != exp_opcode_q) begin
        status_d = cfrc_pkg::STAT_OPCODE;
      end else if (!skip_crc_q && got != crc_q) begin
        status_d = cfrc_pkg::STAT_CRC;
      end else begin
        status_d = cfrc_pkg::STAT_OK;
      end
      end_d  = 1'b1;
      fop_d  = op_q;
      plen_d = len_m1[10:0];
      pos_d  = PosW'(0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      start_q     <= 8'h00;
      len_q       <= 16'h0000;
      op_q        <= 8'h00;
      crc_q       <= 16'h0000;
      crcl_q      <= 8'h00;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        pos_q       <= pos_d;
        start_q     <= start_d;
        len_q       <= len_d;
        op_q        <= op_d;
        crc_q       <= crc_d;
        crcl_q      <= crcl_d;
        out_valid_q <= 1'b1;
      end else if (st_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      end_q    <= end_d;
      fop_q    <= fop_d;
      plen_q   <= plen_d;
    end
  end

  assign st_o.valid          = out_valid_q;
  assign st_o.status         = status_q;
  assign st_o.frame_end      = end_q;
  assign st_o.frame_opcode   = fop_q;
  assign st_o.payload_length = plen_q;

endmodule

@@ hdl/cfrc_checker.sv @@
// Port-level assertions for the command frame receive checker, bound to the
// checker module. Depends on cfrc_pkg and command_frame_receive_checker_assert.svh.
`include "command_frame_receive_checker_assert.svh"

module cfrc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  status_i,
  input logic        frame_end_i,
  input logic [7:0]  frame_opcode_i,
  input logic [10:0] payload_length_i
);

  `CFRC_ASSERT_NXT(a_accept_gives_result, in_valid_i && in_ready_i, out_valid_i)
  `CFRC_ASSERT_IMP(a_ready_when_free, !out_valid_i || out_ready_i, in_ready_i)
  `CFRC_ASSERT_IMP(a_mid_frame_fields, out_valid_i && !frame_end_i,
                   status_i == cfrc_pkg::STAT_IN_FRAME && frame_opcode_i == 8'h00 &&
                   payload_length_i == 11'd0)
  `CFRC_ASSERT_IMP(a_end_has_verdict, out_valid_i && frame_end_i,
                   status_i != cfrc_pkg::STAT_IN_FRAME)
  `CFRC_ASSERT_NXT(a_stall_holds, out_valid_i && !out_ready_i,
                   out_valid_i && $stable(status_i) && $stable(frame_end_i))

endmodule

bind command_frame_receive_checker cfrc_checker u_cfrc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (rx_i.valid),
  .in_ready_i       (rx_i.ready),
  .out_valid_i      (st_o.valid),
  .out_ready_i      (st_o.ready),
  .status_i         (st_o.status),
  .frame_end_i      (st_o.frame_end),
  .frame_opcode_i   (st_o.frame_opcode),
  .payload_length_i (st_o.payload_length)
);
